@@ src/pszp_pkg.sv @@
// Shared types, codes and helper functions for the pair spread z-score block.
// No dependencies; every other file refers to this package by scoped names.
package pszp_pkg;

  typedef struct packed {
    logic signed [31:0] price_first;
    logic signed [31:0] price_second;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         position;
    logic signed [15:0] z_score;
    logic signed [31:0] hedge_ratio;
    logic signed [31:0] spread_value;
  } out_item_t;

  typedef enum logic [1:0] {
    CFG_ALPHA = 2'd0,
    CFG_FLOOR = 2'd1,
    CFG_ENTRY = 2'd2,
    CFG_EXIT  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    POS_HOLD = 2'd0,
    POS_BUY  = 2'd1,
    POS_SELL = 2'd2
  } pos_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_MF, ST_MS, ST_VA, ST_VB, ST_VC, ST_VD, ST_VE, ST_VF, ST_VG,
    ST_CB, ST_CC, ST_CD, ST_CE, ST_CF, ST_BC, ST_BW, ST_BF, ST_SP, ST_DS,
    ST_MP, ST_MQ, ST_WB, ST_WC, ST_WD, ST_WE, ST_WF, ST_WG, ST_RT, ST_RW,
    ST_ZC, ST_ZW, ST_ZF
  } state_t;

  // request to / response from the shared divide and root unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [5:0]  steps;
    logic [63:0] rem0;
    logic [63:0] src;
    logic [63:0] den;
  } iter_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } iter_rsp_t;

  localparam logic [5:0]  BETA_STEPS  = 6'd31;
  localparam logic [5:0]  ROOT_STEPS  = 6'd32;
  localparam logic [5:0]  Z_STEPS     = 6'd15;
  localparam logic [15:0] ALPHA_RST   = 16'd655;
  localparam logic [31:0] FLOOR_RST   = 32'd4295;
  localparam logic [14:0] ENTRY_RST   = 15'd512;
  localparam logic [14:0] EXIT_RST    = 15'd128;
  localparam logic [16:0] ONE_Q16     = 17'h10000;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  function automatic logic [32:0] diff33(input logic [31:0] x, input logic [31:0] m);
    return {x[31], x} - {m[31], m};
  endfunction

  function automatic logic [31:0] mag33(input logic [32:0] d);
    logic [32:0] n;
    n = ~d + 33'd1;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

  function automatic logic [31:0] ewma_step(input logic [31:0] m, input logic neg,
                                            input logic [31:0] t);
    logic [33:0] s;
    s = neg ? ({{2{m[31]}}, m} - {2'b00, t}) : ({{2{m[31]}}, m} + {2'b00, t});
    return s[31:0];
  endfunction

endpackage

@@ src/pszp_iter.sv @@
// Shared iterative unit: restoring division one quotient bit a cycle, or
// integer square root one root bit a cycle. Depends on pszp_pkg.
module pszp_iter (
  input  logic                clk,
  input  logic                rst_n,
  input  pszp_pkg::iter_req_t req,
  output pszp_pkg::iter_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        sqrt_r, sqrt_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [65:0] rem_r, rem_nxt;
  logic [63:0] src_r, src_nxt;
  logic [63:0] den_r, den_nxt;
  logic [31:0] q_r, q_nxt;

  logic [65:0] trial;
  logic [65:0] cand;

  always_comb begin
    if (sqrt_r) begin
      cand  = {rem_r[63:0], src_r[63:62]};
      trial = {32'd0, q_r, 2'b01};
    end else begin
      cand  = {rem_r[64:0], src_r[63]};
      trial = {2'b00, den_r};
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    src_nxt  = src_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.is_sqrt;
      cnt_nxt  = req.steps;
      rem_nxt  = {2'b00, req.rem0};
      src_nxt  = req.src;
      den_nxt  = req.den;
      q_nxt    = '0;
    end else if (busy_r) begin
      if (cand >= trial) begin
        rem_nxt = cand - trial;
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = cand;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      src_nxt = sqrt_r ? {src_r[61:0], 2'b00} : {src_r[62:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sqrt_r <= sqrt_nxt;
    rem_r  <= rem_nxt;
    src_r  <= src_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.res  = q_r;

endmodule

@@ src/pair_spread_zscore_position.sv @@
// Top level of the pair spread z-score position block: sequencer, shared
// 32x32 multiplier and statistics state. Depends on pszp_pkg and pszp_iter.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid / in_stall  | pszp_pkg::in_item_t
//  out_    | output    | out_valid / out_stall| pszp_pkg::out_item_t
//  cfg_    | input     | cfg_we               | cfg_addr, cfg_wdata
//
// An item passes from acceptance to the result register through 29 sequencer
// steps around the shared multiplier and through the beta divide, the root and
// the z divide in the shared iterative unit. A saturated beta or z skips its
// divide. The next item can be taken in the cycle after the result is loaded.
// in_stall is high from acceptance until the result is loaded in the output
// register; a new item may be taken while that result waits.
// Reset is synchronous: statistics clear to zero, position to hold.
module pair_spread_zscore_position (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pszp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pszp_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata
);

  pszp_pkg::state_t state_r, state_nxt;

  logic [15:0] alpha_r;
  logic [31:0] floor_r;
  logic [14:0] entry_r, exit_r;

  logic [31:0] mf_r, mf_nxt, ms_r, ms_nxt, msp_r, msp_nxt;
  logic [63:0] vsec_r, vsec_nxt, cov_r, cov_nxt, vspr_r, vspr_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [31:0] xi_r, xi_nxt, xj_r, xj_nxt;
  logic [31:0] dm1_r, dm1_nxt, dm2_r, dm2_nxt, dms_r, dms_nxt;
  logic        n1_r, n1_nxt, n2_r, n2_nxt, nds_r, nds_nxt, nprod_r, nprod_nxt;
  logic        sat_r, sat_nxt;
  logic [63:0] prod_r, acc_r, acc_nxt, sq_r, sq_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  logic [31:0] beta_r, beta_nxt, spread_r, spread_nxt;
  pszp_pkg::out_item_t out_data_r, out_data_nxt;

  logic [31:0] mul_a, mul_b;
  logic [95:0] sc_sum;
  logic [63:0] sc_res;
  logic [63:0] flo, vs_sec, vs_spr, cmag;
  logic [16:0] ma;
  logic        bsat, zsat, xfer;

  pszp_pkg::iter_req_t iter_req;
  pszp_pkg::iter_rsp_t iter_rsp;

  pszp_iter u_iter (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (iter_req),
    .rsp   (iter_rsp)
  );

  assign ma     = pszp_pkg::ONE_Q16 - {1'b0, alpha_r};
  assign sc_sum = {prod_r, 32'd0} + {32'd0, acc_r};
  assign sc_res = sc_sum[79:16];
  assign flo    = (floor_r == 32'd0) ? 64'd1 : {32'd0, floor_r};
  assign vs_sec = (vsec_r > flo) ? vsec_r : flo;
  assign vs_spr = (vspr_r > flo) ? vspr_r : flo;
  assign cmag   = cov_r[63] ? (~cov_r + 64'd1) : cov_r;
  assign bsat   = ({15'd0, cmag} >= {vs_sec, 15'd0});
  assign zsat   = ({7'd0, dms_r} >= {iter_rsp.res, 7'd0});
  assign xfer   = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != pszp_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pszp_pkg::ST_IDLE: if (in_valid) state_nxt = pszp_pkg::ST_MF;
      pszp_pkg::ST_MF:   state_nxt = pszp_pkg::ST_MS;
      pszp_pkg::ST_MS:   state_nxt = pszp_pkg::ST_VA;
      pszp_pkg::ST_VA:   state_nxt = pszp_pkg::ST_VB;
      pszp_pkg::ST_VB:   state_nxt = pszp_pkg::ST_VC;
      pszp_pkg::ST_VC:   state_nxt = pszp_pkg::ST_VD;
      pszp_pkg::ST_VD:   state_nxt = pszp_pkg::ST_VE;
      pszp_pkg::ST_VE:   state_nxt = pszp_pkg::ST_VF;
      pszp_pkg::ST_VF:   state_nxt = pszp_pkg::ST_VG;
      pszp_pkg::ST_VG:   state_nxt = pszp_pkg::ST_CB;
      pszp_pkg::ST_CB:   state_nxt = pszp_pkg::ST_CC;
      pszp_pkg::ST_CC:   state_nxt = pszp_pkg::ST_CD;
      pszp_pkg::ST_CD:   state_nxt = pszp_pkg::ST_CE;
      pszp_pkg::ST_CE:   state_nxt = pszp_pkg::ST_CF;
      pszp_pkg::ST_CF:   state_nxt = pszp_pkg::ST_BC;
      pszp_pkg::ST_BC:   state_nxt = bsat ? pszp_pkg::ST_BF : pszp_pkg::ST_BW;
      pszp_pkg::ST_BW:   if (iter_rsp.done) state_nxt = pszp_pkg::ST_BF;
      pszp_pkg::ST_BF:   state_nxt = pszp_pkg::ST_SP;
      pszp_pkg::ST_SP:   state_nxt = pszp_pkg::ST_DS;
      pszp_pkg::ST_DS:   state_nxt = pszp_pkg::ST_MP;
      pszp_pkg::ST_MP:   state_nxt = pszp_pkg::ST_MQ;
      pszp_pkg::ST_MQ:   state_nxt = pszp_pkg::ST_WB;
      pszp_pkg::ST_WB:   state_nxt = pszp_pkg::ST_WC;
      pszp_pkg::ST_WC:   state_nxt = pszp_pkg::ST_WD;
      pszp_pkg::ST_WD:   state_nxt = pszp_pkg::ST_WE;
      pszp_pkg::ST_WE:   state_nxt = pszp_pkg::ST_WF;
      pszp_pkg::ST_WF:   state_nxt = pszp_pkg::ST_WG;
      pszp_pkg::ST_WG:   state_nxt = pszp_pkg::ST_RT;
      pszp_pkg::ST_RT:   state_nxt = pszp_pkg::ST_RW;
      pszp_pkg::ST_RW:   if (iter_rsp.done) state_nxt = pszp_pkg::ST_ZC;
      pszp_pkg::ST_ZC:   state_nxt = zsat ? pszp_pkg::ST_ZF : pszp_pkg::ST_ZW;
      pszp_pkg::ST_ZW:   if (iter_rsp.done) state_nxt = pszp_pkg::ST_ZF;
      pszp_pkg::ST_ZF:   if (xfer) state_nxt = pszp_pkg::ST_IDLE;
      default:           state_nxt = pszp_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    logic [32:0] d33;
    logic [31:0] bm32;
    logic [49:0] xi50, pm50, sp50;
    logic [14:0] zm;
    logic [15:0] z16;
    logic [16:0] zs, ent, ext;
    logic        cneg, pneg;
    logic [63:0] cm;

    d33 = '0; bm32 = '0; xi50 = '0; pm50 = '0; sp50 = '0;
    zm = '0; z16 = '0; zs = '0; ent = '0; ext = '0;
    cneg = 1'b0; pneg = 1'b0; cm = '0;

    mf_nxt = mf_r; ms_nxt = ms_r; msp_nxt = msp_r;
    vsec_nxt = vsec_r; cov_nxt = cov_r; vspr_nxt = vspr_r; pos_nxt = pos_r;
    xi_nxt = xi_r; xj_nxt = xj_r;
    dm1_nxt = dm1_r; dm2_nxt = dm2_r; dms_nxt = dms_r;
    n1_nxt = n1_r; n2_nxt = n2_r; nds_nxt = nds_r; nprod_nxt = nprod_r;
    sat_nxt = sat_r;
    acc_nxt = acc_r; sq_nxt = sq_r; t1_nxt = t1_r; t2_nxt = t2_r;
    beta_nxt = beta_r; spread_nxt = spread_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mul_a = '0;
    mul_b = '0;
    iter_req = '0;

    case (state_r)
      pszp_pkg::ST_IDLE: begin
        if (in_valid) begin
          xi_nxt  = in_data.price_first;
          xj_nxt  = in_data.price_second;
          d33     = pszp_pkg::diff33(in_data.price_first, mf_r);
          n1_nxt  = d33[32];
          dm1_nxt = pszp_pkg::mag33(d33);
          d33     = pszp_pkg::diff33(in_data.price_second, ms_r);
          n2_nxt  = d33[32];
          dm2_nxt = pszp_pkg::mag33(d33);
        end
      end
      pszp_pkg::ST_MF: begin
        mul_a = dm1_r;
        mul_b = {16'd0, alpha_r};
      end
      pszp_pkg::ST_MS: begin
        mf_nxt = pszp_pkg::ewma_step(mf_r, n1_r, prod_r[47:16]);
        mul_a  = dm2_r;
        mul_b  = {16'd0, alpha_r};
      end
      pszp_pkg::ST_VA: begin
        ms_nxt = pszp_pkg::ewma_step(ms_r, n2_r, prod_r[47:16]);
        mul_a  = vsec_r[31:0];
        mul_b  = {15'd0, ma};
      end
      pszp_pkg::ST_VB: begin
        acc_nxt = prod_r;
        mul_a   = vsec_r[63:32];
        mul_b   = {15'd0, ma};
      end
      pszp_pkg::ST_VC: begin
        t1_nxt = sc_res;
        mul_a  = dm2_r;
        mul_b  = dm2_r;
      end
      pszp_pkg::ST_VD: begin
        sq_nxt = prod_r;
        mul_a  = prod_r[31:0];
        mul_b  = {16'd0, alpha_r};
      end
      pszp_pkg::ST_VE: begin
        acc_nxt = prod_r;
        mul_a   = sq_r[63:32];
        mul_b   = {16'd0, alpha_r};
      end
      pszp_pkg::ST_VF: begin
        t2_nxt = sc_res;
        mul_a  = cmag[31:0];
        mul_b  = {15'd0, ma};
      end
      pszp_pkg::ST_VG: begin
        vsec_nxt = pszp_pkg::sat_add64(t1_r, t2_r);
        acc_nxt  = prod_r;
        mul_a    = cmag[63:32];
        mul_b    = {15'd0, ma};
      end
      pszp_pkg::ST_CB: begin
        t1_nxt = sc_res;
        mul_a  = dm1_r;
        mul_b  = dm2_r;
      end
      pszp_pkg::ST_CC: begin
        sq_nxt = prod_r;
        mul_a  = prod_r[31:0];
        mul_b  = {16'd0, alpha_r};
      end
      pszp_pkg::ST_CD: begin
        acc_nxt = prod_r;
        mul_a   = sq_r[63:32];
        mul_b   = {16'd0, alpha_r};
      end
      pszp_pkg::ST_CE: begin
        t2_nxt = sc_res;
      end
      pszp_pkg::ST_CF: begin
        cneg = cov_r[63];
        pneg = n1_r ^ n2_r;
        if (t1_r == 64'd0) cneg = pneg;
        if (cneg == pneg) begin
          cm = pszp_pkg::sat_add64(t1_r, t2_r);
        end else if (t1_r >= t2_r) begin
          cm = t1_r - t2_r;
        end else begin
          cm   = t2_r - t1_r;
          cneg = pneg;
        end
        if (cneg) cov_nxt = cm[63] ? {1'b1, 63'd0} : (~cm + 64'd1);
        else      cov_nxt = cm[63] ? {1'b0, {63{1'b1}}} : cm;
      end
      pszp_pkg::ST_BC: begin
        sat_nxt        = bsat;
        iter_req.start = !bsat;
        iter_req.steps = pszp_pkg::BETA_STEPS;
        iter_req.rem0  = {15'd0, cmag[63:15]};
        iter_req.src   = {cmag[14:0], 49'd0};
        iter_req.den   = vs_sec;
      end
      pszp_pkg::ST_BF: begin
        if (sat_r) bm32 = cov_r[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else       bm32 = {1'b0, iter_rsp.res[30:0]};
        beta_nxt  = cov_r[63] ? (~bm32 + 32'd1) : bm32;
        nprod_nxt = cov_r[63] ^ xj_r[31];
        mul_a     = bm32;
        mul_b     = xj_r[31] ? (~xj_r + 32'd1) : xj_r;
      end
      pszp_pkg::ST_SP: begin
        xi50 = {{18{xi_r[31]}}, xi_r};
        pm50 = {2'b00, prod_r[63:16]};
        sp50 = nprod_r ? (xi50 + pm50) : (xi50 - pm50);
        if (sp50[49] && !(&sp50[48:31]))     spread_nxt = 32'h8000_0000;
        else if (!sp50[49] && (|sp50[48:31])) spread_nxt = 32'h7FFF_FFFF;
        else                                   spread_nxt = sp50[31:0];
      end
      pszp_pkg::ST_DS: begin
        d33     = pszp_pkg::diff33(spread_r, msp_r);
        nds_nxt = d33[32];
        dms_nxt = pszp_pkg::mag33(d33);
      end
      pszp_pkg::ST_MP: begin
        mul_a = dms_r;
        mul_b = {16'd0, alpha_r};
      end
      pszp_pkg::ST_MQ: begin
        msp_nxt = pszp_pkg::ewma_step(msp_r, nds_r, prod_r[47:16]);
        mul_a   = vspr_r[31:0];
        mul_b   = {15'd0, ma};
      end
      pszp_pkg::ST_WB: begin
        acc_nxt = prod_r;
        mul_a   = vspr_r[63:32];
        mul_b   = {15'd0, ma};
      end
      pszp_pkg::ST_WC: begin
        t1_nxt = sc_res;
        mul_a  = dms_r;
        mul_b  = dms_r;
      end
      pszp_pkg::ST_WD: begin
        sq_nxt = prod_r;
        mul_a  = prod_r[31:0];
        mul_b  = {16'd0, alpha_r};
      end
      pszp_pkg::ST_WE: begin
        acc_nxt = prod_r;
        mul_a   = sq_r[63:32];
        mul_b   = {16'd0, alpha_r};
      end
      pszp_pkg::ST_WF: begin
        t2_nxt = sc_res;
      end
      pszp_pkg::ST_WG: begin
        vspr_nxt = pszp_pkg::sat_add64(t1_r, t2_r);
      end
      pszp_pkg::ST_RT: begin
        iter_req.start   = 1'b1;
        iter_req.is_sqrt = 1'b1;
        iter_req.steps   = pszp_pkg::ROOT_STEPS;
        iter_req.src     = vs_spr;
      end
      pszp_pkg::ST_ZC: begin
        sat_nxt        = zsat;
        iter_req.start = !zsat;
        iter_req.steps = pszp_pkg::Z_STEPS;
        iter_req.rem0  = {39'd0, dms_r[31:7]};
        iter_req.src   = {dms_r[6:0], 57'd0};
        iter_req.den   = {32'd0, iter_rsp.res};
      end
      pszp_pkg::ST_ZF: begin
        zm = iter_rsp.res[14:0];
        if (sat_r)      z16 = nds_r ? 16'h8000 : 16'h7FFF;
        else if (nds_r) z16 = ~{1'b0, zm} + 16'd1;
        else            z16 = {1'b0, zm};
        zs  = {z16[15], z16};
        ent = {2'b00, entry_r};
        ext = {2'b00, exit_r};
        if (xfer) begin
          case (pos_r)
            pszp_pkg::POS_HOLD: begin
              if ($signed(zs) > $signed(ent))       pos_nxt = pszp_pkg::POS_SELL;
              else if ($signed(zs) < -$signed(ent)) pos_nxt = pszp_pkg::POS_BUY;
              else                                  pos_nxt = pos_r;
            end
            pszp_pkg::POS_BUY: begin
              if ($signed(zs) > -$signed(ext)) pos_nxt = pszp_pkg::POS_HOLD;
              else                             pos_nxt = pos_r;
            end
            default: begin
              if ($signed(zs) < $signed(ext)) pos_nxt = pszp_pkg::POS_HOLD;
              else                            pos_nxt = pos_r;
            end
          endcase
          out_valid_nxt             = 1'b1;
          out_data_nxt.position     = pos_nxt;
          out_data_nxt.z_score      = z16;
          out_data_nxt.hedge_ratio  = beta_r;
          out_data_nxt.spread_value = spread_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pszp_pkg::ST_IDLE;
      alpha_r     <= pszp_pkg::ALPHA_RST;
      floor_r     <= pszp_pkg::FLOOR_RST;
      entry_r     <= pszp_pkg::ENTRY_RST;
      exit_r      <= pszp_pkg::EXIT_RST;
      mf_r        <= '0;
      ms_r        <= '0;
      msp_r       <= '0;
      vsec_r      <= '0;
      cov_r       <= '0;
      vspr_r      <= '0;
      pos_r       <= pszp_pkg::POS_HOLD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mf_r        <= mf_nxt;
      ms_r        <= ms_nxt;
      msp_r       <= msp_nxt;
      vsec_r      <= vsec_nxt;
      cov_r       <= cov_nxt;
      vspr_r      <= vspr_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          pszp_pkg::CFG_ALPHA: alpha_r <= cfg_wdata[15:0];
          pszp_pkg::CFG_FLOOR: floor_r <= cfg_wdata;
          pszp_pkg::CFG_ENTRY: entry_r <= cfg_wdata[14:0];
          pszp_pkg::CFG_EXIT:  exit_r  <= cfg_wdata[14:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= mul_a * mul_b;
    xi_r       <= xi_nxt;
    xj_r       <= xj_nxt;
    dm1_r      <= dm1_nxt;
    dm2_r      <= dm2_nxt;
    dms_r      <= dms_nxt;
    n1_r       <= n1_nxt;
    n2_r       <= n2_nxt;
    nds_r      <= nds_nxt;
    nprod_r    <= nprod_nxt;
    sat_r      <= sat_nxt;
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    t1_r       <= t1_nxt;
    t2_r       <= t2_nxt;
    beta_r     <= beta_nxt;
    spread_r   <= spread_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench for pair_spread_zscore_position: random and directed price ticks,
// bit-exact prediction of position, z, beta and spread. Depends on pszp_pkg.
`timescale 1ns / 1ps

class pair_tick_scoreboard;
  logic [15:0] alpha;
  logic [31:0] vfloor;
  logic [14:0] entry_thr;
  logic [14:0] exit_thr;
  logic signed [31:0] avg_first, avg_second, avg_spread;
  logic [63:0] var_second, var_spread;
  logic signed [63:0] cov;
  pszp_pkg::pos_t pos;
  pszp_pkg::out_item_t pending[$];
  int errors;

  function new();
    alpha = pszp_pkg::ALPHA_RST; vfloor = pszp_pkg::FLOOR_RST;
    entry_thr = pszp_pkg::ENTRY_RST; exit_thr = pszp_pkg::EXIT_RST;
    avg_first = 0; avg_second = 0; avg_spread = 0;
    var_second = 0; var_spread = 0; cov = 0; pos = pszp_pkg::POS_HOLD; errors = 0;
  endfunction

  function void write_reg(pszp_pkg::cfg_idx_t idx, logic [31:0] v);
    case (idx)
      pszp_pkg::CFG_ALPHA: alpha = v[15:0];
      pszp_pkg::CFG_FLOOR: vfloor = v;
      pszp_pkg::CFG_ENTRY: entry_thr = v[14:0];
      pszp_pkg::CFG_EXIT:  exit_thr = v[14:0];
      default: begin
      end
    endcase
  endfunction

  function automatic logic [63:0] scale(logic [63:0] p, logic [16:0] m);
    if (m >= 17'h10000) return p;
    return (p >> 16) * m + (((p & 64'hFFFF) * m) >> 16);
  endfunction

  function automatic logic [63:0] absv(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [31:0] track(logic signed [31:0] m, logic signed [63:0] d);
    logic [63:0] t;
    t = scale(absv(d), {1'b0, alpha});
    return d < 0 ? 32'(64'(m) - t) : 32'(64'(m) + t);
  endfunction

  function automatic logic [63:0] spread_var(logic [63:0] v, logic signed [63:0] d);
    logic [63:0] dm, t1, t2, s;
    dm = absv(d);
    t1 = scale(v, 17'h10000 - alpha);
    t2 = scale(dm * dm, {1'b0, alpha});
    s = t1 + t2;
    return s < t1 ? '1 : s;
  endfunction

  function automatic logic [63:0] ratio_q16(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, r, f;
    logic c;
    q = num / den; r = num % den; f = 0;
    if (q >= 65536) return 64'h1_0000_0000;
    for (int i = 0; i < 16; i++) begin
      c = r[63]; r = r << 1; f = f << 1;
      if (c || r >= den) begin
        r = r - den; f[0] = 1'b1;
      end
    end
    return (q << 16) | f;
  endfunction

  function automatic logic [63:0] root(logic [63:0] v);
    logic [63:0] r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b); r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function void note_tick(pszp_pkg::in_item_t it);
    logic signed [63:0] xi, xj, di, dj, beta, prod, ds, z;
    logic [63:0] flo, c1, c2, cm, vs, bm, sd, zm;
    logic cneg, pneg;
    logic signed [31:0] spr;
    pszp_pkg::out_item_t e;
    flo = vfloor == 0 ? 64'd1 : 64'(vfloor);
    xi = it.price_first; xj = it.price_second;
    di = xi - avg_first; dj = xj - avg_second;
    avg_first = track(avg_first, di);
    avg_second = track(avg_second, dj);
    var_second = spread_var(var_second, dj);
    cneg = cov < 0;
    c1 = scale(absv(cov), 17'h10000 - alpha);
    pneg = (di < 0) != (dj < 0);
    c2 = scale(absv(di) * absv(dj), {1'b0, alpha});
    if (c1 == 0) cneg = pneg;
    if (cneg == pneg) begin
      cm = c1 + c2;
      if (cm < c1) cm = '1;
    end else if (c1 >= c2) cm = c1 - c2;
    else begin
      cm = c2 - c1; cneg = pneg;
    end
    if (cneg) cov = cm[63] ? 64'sh8000_0000_0000_0000 : -$signed(cm);
    else cov = cm[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(cm);
    vs = var_second > flo ? var_second : flo;
    bm = ratio_q16(absv(cov), vs);
    if (cov < 0) beta = bm >= 64'h8000_0000 ? -64'sh8000_0000 : -$signed(bm);
    else beta = bm > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : $signed(bm);
    prod = beta * xj;
    prod = prod < 0 ? -$signed(absv(prod) >> 16) : $signed(absv(prod) >> 16);
    ds = xi - prod;
    spr = ds > 64'sh7FFF_FFFF ? 32'sh7FFF_FFFF :
          ds < -64'sh8000_0000 ? 32'sh8000_0000 : 32'(ds);
    ds = 64'(spr) - 64'(avg_spread);
    avg_spread = track(avg_spread, ds);
    var_spread = spread_var(var_spread, ds);
    vs = var_spread > flo ? var_spread : flo;
    sd = root(vs);
    if (sd == 0) sd = 1;
    zm = (absv(ds) << 8) / sd;
    if (ds < 0) z = zm >= 32768 ? -64'sd32768 : -$signed(zm);
    else z = zm > 32767 ? 64'sd32767 : $signed(zm);
    case (pos)
      pszp_pkg::POS_HOLD: begin
        if (z > $signed(64'(entry_thr))) pos = pszp_pkg::POS_SELL;
        else if (z < -$signed(64'(entry_thr))) pos = pszp_pkg::POS_BUY;
      end
      pszp_pkg::POS_BUY: if (z > -$signed(64'(exit_thr))) pos = pszp_pkg::POS_HOLD;
      default: if (z < $signed(64'(exit_thr))) pos = pszp_pkg::POS_HOLD;
    endcase
    e.position = pos; e.z_score = 16'(z); e.hedge_ratio = 32'(beta); e.spread_value = spr;
    pending.push_back(e);
  endfunction

  function void check_result(pszp_pkg::out_item_t got);
    pszp_pkg::out_item_t e;
    if (pending.size() == 0) begin
      $error("unexpected result %h", got); errors++; return;
    end
    e = pending.pop_front();
    if (got.position !== e.position) begin
      $error("position exp %0d got %0d", e.position, got.position); errors++;
    end
    if (got.z_score !== e.z_score) begin
      $error("z_score exp %0d got %0d", e.z_score, got.z_score); errors++;
    end
    if (got.hedge_ratio !== e.hedge_ratio) begin
      $error("hedge_ratio exp %0d got %0d", e.hedge_ratio, got.hedge_ratio); errors++;
    end
    if (got.spread_value !== e.spread_value) begin
      $error("spread_value exp %0d got %0d", e.spread_value, got.spread_value); errors++;
    end
  endfunction
endclass

module tb_top;
  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  pszp_pkg::in_item_t in_data = '0;
  pszp_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  pair_tick_scoreboard sb = new();
  int cycles = 0, ticks = 0, results = 0;
  int stall_left = 0;
  bit stall_busy = 1;

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 3);
  endfunction

  always begin
    #2 clk = 1; #2 clk = 0;
  end

  pair_spread_zscore_position u_top (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
      results <= results + 1;
    end
    if (!stall_busy) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= gap_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_tick(logic [31:0] pf, logic [31:0] ps, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    repeat (g + 1) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= '{price_first: pf, price_second: ps};
    do @(posedge clk); while (in_stall);
    sb.note_tick(in_data);
    ticks++;
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(pszp_pkg::cfg_idx_t idx, logic [31:0] v);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic set_all(logic [15:0] a, logic [31:0] f, logic [14:0] en, logic [14:0] ex);
    drain();
    write_reg(pszp_pkg::CFG_ALPHA, a); write_reg(pszp_pkg::CFG_FLOOR, f);
    write_reg(pszp_pkg::CFG_ENTRY, en); write_reg(pszp_pkg::CFG_EXIT, ex);
    cfg_we <= 1'b0;
  endtask

  task automatic random_walk(int n, int step);
    logic signed [31:0] p1, p2;
    p1 = $urandom_range(0, 32'h00FF_FFFF); p2 = $urandom_range(0, 32'h00FF_FFFF);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_tick($urandom, $urandom, 1);
        default: begin
          p2 = p2 + $signed($urandom_range(0, 2 * step)) - step;
          p1 = p2 + $signed($urandom_range(0, 8 * step)) - 4 * step;
          send_tick(p1, p2, 1);
        end
      endcase
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, spikes to drive every position transition
    send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_tick(32'h8000_0000, 32'h8000_0000, 0);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, 0);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000, 0);
    send_tick(0, 0, 0);
    send_tick(32'hFFFF_FFFF, 32'h0000_0001, 0);
    for (int i = 0; i < 4; i++) send_tick(32'h0001_0000, 32'h0001_0000, 0);
    send_tick(32'h0100_0000, 32'h0001_0000, 0);
    send_tick(32'h0001_0000, 32'h0001_0000, 0);
    send_tick(32'hFF00_0000, 32'h0001_0000, 0);
    send_tick(32'h0001_0000, 32'h0001_0000, 0);
    set_all(16'd0, 32'd0, 15'd0, 15'd0);
    send_tick(32'h1234_5678, 32'h0000_1000, 0);
    send_tick(32'hEDCB_A988, 32'h0000_2000, 0);
    set_all(16'hFFFF, 32'hFFFF_FFFF, 15'h7FFF, 15'h7FFF);
    send_tick(32'h0010_0000, 32'hFFF0_0000, 0);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF, 0);
    set_all(16'd1, 32'd1, 15'd256, 15'd0);
    send_tick(32'h0002_0000, 32'h0003_0000, 0);
    // random phases across settings
    set_all(16'd655, 32'd4295, 15'd512, 15'd128);
    random_walk(300, 4000);
    stall_busy = 0;
    drain();
    stall_busy = 1;
    set_all(16'd8000, 32'd100, 15'd200, 15'd50);
    random_walk(250, 20000);
    set_all(16'hFFFF, 32'd1, 15'd0, 15'd0);
    random_walk(100, 100);
    for (int k = 0; k < 3; k++) begin
      set_all(16'($urandom_range(0, 16'hFFFF)), $urandom,
              15'($urandom_range(0, 15'h7FFF)), 15'($urandom_range(0, 15'h7FFF)));
      random_walk(40, $urandom_range(1, 1 << 20));
    end
    set_all(16'd3000, 32'd50, 15'd300, 15'd100);
    random_walk(200, 3000);
    drain();
    $display("Sent %0d price ticks over several register settings; %0d results checked.",
             ticks, results);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

@@ pair_spread_zscore_position.f @@
src/pszp_pkg.sv
src/pszp_iter.sv
src/pair_spread_zscore_position.sv
tb/tb_top.sv
